// ===== src/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear-probe hash table
// Table geometry, field widths, status and opcode codes, and the structs
// that pass between the probe sequencer and the slot store.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // Table geometry (slot count must be a power of two for the home-slot mask)
   localparam int TABLE_SIZE = 8;
   localparam int SLOT_W     = $clog2(TABLE_SIZE);

   // Beat field widths
   localparam int KEY_W      = 31;
   localparam int STATUS_W   = 2;
   localparam int RSP_SLOT_W = 3;

   // Opcodes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [KEY_W-1:0]  key_type;

   // Sequencer to store: one read address per cycle, one write port
   typedef struct packed {
      slot_type rd_addr;
      logic     wr_en;
      slot_type wr_addr;
      key_type  wr_key;
   } store_req_type;

   // Store to sequencer: registered contents of the slot read last cycle
   typedef struct packed {
      logic    used;
      key_type key;
   } store_rsp_type;

   // Home slot: key modulo the table size
   function automatic slot_type home_slot(input key_type key);
      return slot_type'(key % TABLE_SIZE);
   endfunction

   // Next probe slot with wraparound
   function automatic slot_type next_slot(input slot_type s);
      if (s == slot_type'(TABLE_SIZE - 1)) begin
         return '0;
      end
      return s + slot_type'(1);
   endfunction

   // Slot number as reported on the response: low bits only
   function automatic logic [RSP_SLOT_W-1:0] rsp_slot(input slot_type s);
      logic [SLOT_W+RSP_SLOT_W-1:0] wide;
      wide = {{RSP_SLOT_W{1'b0}}, s};
      return wide[RSP_SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/lpht_slot_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_slot_store: key memory and occupancy bits
// Key memory with one write and one registered read per cycle; occupancy
// bits in flip-flops that reset clears at once.
// ----------------------------------------------------------------------------
module lpht_slot_store (
   input  logic                   clock,
   input  logic                   reset,
   input  lpht_pkg::store_req_type store_req,
   output lpht_pkg::store_rsp_type store_rsp
);
   import lpht_pkg::*;

   key_type                 key_mem [TABLE_SIZE];
   key_type                 key_rd_ff;
   logic [TABLE_SIZE-1:0]   used_ff;
   logic [TABLE_SIZE-1:0]   used_in;
   logic                    used_rd_ff;

   // Write key and read the addressed slot
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         key_mem[store_req.wr_addr] <= store_req.wr_key;
      end
      key_rd_ff <= key_mem[store_req.rd_addr];
   end

   // Mark written slot as occupied
   always_comb begin
      used_in = used_ff;
      if (store_req.wr_en) begin
         used_in[store_req.wr_addr] = 1'b1;
      end
   end

   // Hold occupancy; clear the whole table on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         used_rd_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         used_rd_ff <= used_ff[store_req.rd_addr];
      end
   end

   assign store_rsp.used = used_rd_ff;
   assign store_rsp.key  = key_rd_ff;

endmodule
`default_nettype wire

// ===== src/lpht_probe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpht_probe_ctrl: probe sequencer and slot compare
// Walks the table one slot per cycle from the home slot unless stalled, tests
// each slot with a single compare unit, writes on insert hit and registers the result.
// ----------------------------------------------------------------------------
module lpht_probe_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [lpht_pkg::KEY_W-1:0]         req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lpht_pkg::RSP_SLOT_W-1:0]    rsp_slot_index,
   output lpht_pkg::store_req_type            store_req,
   input  lpht_pkg::store_rsp_type            store_rsp
);
   import lpht_pkg::*;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_PROBE = 1'b1;

   logic                      state_ff, state_in;
   logic                      op_ff, op_in;
   key_type                   key_ff, key_in;
   slot_type                  pos_ff, pos_in;
   slot_type                  cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [RSP_SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   logic                      req_accept;
   logic                      out_free;
   logic                      slot_hit;
   logic                      last_probe;
   logic                      done;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Compare unit: empty slot for insert, matching occupied slot for search
   always_comb begin
      if (op_ff == OP_INSERT) begin
         slot_hit = !store_rsp.used;
      end else begin
         slot_hit = store_rsp.used && (store_rsp.key == key_ff);
      end
   end

   assign last_probe = (cnt_ff == slot_type'(TABLE_SIZE - 1));
   assign done       = (state_ff == S_PROBE) && out_free && (slot_hit || last_probe);

   // Sequencer: accept, probe one slot per cycle unless a result is stalled, finish on hit or full lap
   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      pos_in            = pos_ff;
      cnt_in            = cnt_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      store_req.rd_addr = pos_ff;
      store_req.wr_en   = 1'b0;
      store_req.wr_addr = pos_ff;
      store_req.wr_key  = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            store_req.rd_addr = home_slot(req_key);
            if (req_accept) begin
               state_in = S_PROBE;
               op_in    = req_opcode;
               key_in   = req_key;
               pos_in   = home_slot(req_key);
               cnt_in   = '0;
            end
         end
         S_PROBE: begin
            if (out_free) begin
               if (slot_hit) begin
                  // hit: write on insert, report slot
                  store_req.wr_en = (op_ff == OP_INSERT);
                  rsp_valid_in    = 1'b1;
                  rsp_status_in   = (op_ff == OP_INSERT) ? ST_INSERTED : ST_FOUND;
                  rsp_slot_in     = rsp_slot(pos_ff);
                  state_in        = S_IDLE;
               end else if (last_probe) begin
                  // full lap without a hit
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  rsp_slot_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  // advance to the next slot
                  pos_in            = next_slot(pos_ff);
                  cnt_in            = cnt_ff + slot_type'(1);
                  store_req.rd_addr = next_slot(pos_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // Writes happen only on an insert hit while probing
   a_write_on_insert: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> (state_ff == S_PROBE) && (op_ff == OP_INSERT) && slot_hit)
      else $error("slot write outside an insert hit");

   // An accepted beat starts probing at its home slot
   a_accept_probe: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_PROBE) && (cnt_ff == '0))
      else $error("accepted beat did not start probing");

   // A finished probe returns to idle with a result registered
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("finished probe left no result");

   // A stalled probe keeps its slot and count
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) && !out_free |=> $stable(pos_ff) && $stable(cnt_ff))
      else $error("probe advanced while result path was blocked");

endmodule
`default_nettype wire

// ===== src/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: key-only hash table with linear probing
// Insert and search over an 8-slot open-addressed table.
// ----------------------------------------------------------------------------
// Each request beat is an insert (opcode 0) or a search (opcode 1). Probing
// starts at key modulo the slot count and steps forward one slot per cycle
// while no result waits on rsp_stall, with wraparound through a single read
// port of the key memory, for at most one full lap. A request is taken
// while idle and then probes until a hit or a full lap; the next request is
// taken in the cycle after the result is registered, even while that result
// still waits on rsp_stall. Inserts report the slot written or table full;
// searches report the first matching slot in probe order or not found.
// Duplicate keys take another slot. Reset empties the table.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [lpht_pkg::KEY_W-1:0]         req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lpht_pkg::RSP_SLOT_W-1:0]    rsp_slot_index
);
   import lpht_pkg::*;

   store_req_type store_req;
   store_rsp_type store_rsp;

   // Probe sequencer and compare
   lpht_probe_ctrl u_probe_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .store_req      (store_req),
      .store_rsp      (store_rsp)
   );

   // Slot keys and occupancy
   lpht_slot_store u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .store_rsp (store_rsp)
   );

endmodule
`default_nettype wire
